### src/ukf_pkg.sv
// shared types and status codes for the unique-key fifo
// no dependencies
`default_nettype none

package ukf_pkg;

    typedef logic [31:0] word_t;
    typedef logic [2:0]  status_t;

    localparam status_t STATUS_ENQUEUED  = 3'd0;
    localparam status_t STATUS_DUPLICATE = 3'd1;
    localparam status_t STATUS_FULL      = 3'd2;
    localparam status_t STATUS_DEQUEUED  = 3'd3;
    localparam status_t STATUS_EMPTY     = 3'd4;

    localparam logic CMD_ENQUEUE = 1'b0;
    localparam logic CMD_DEQUEUE = 1'b1;

endpackage

`default_nettype wire

### src/ukf_store.sv
// key and value storage of the unique-key fifo: one write port, one registered read port
// depends on ukf_pkg
`default_nettype none

module ukf_store #(
    parameter int DEPTH = 16
) (
    input  wire                      clk,
    input  wire                      wr_en,
    input  wire [$clog2(DEPTH)-1:0]  wr_addr,
    input  ukf_pkg::word_t           wr_key,
    input  ukf_pkg::word_t           wr_value,
    input  wire [$clog2(DEPTH)-1:0]  rd_addr,
    output ukf_pkg::word_t           rd_key,
    output ukf_pkg::word_t           rd_value
);
    import ukf_pkg::*;

    word_t key_mem   [DEPTH];
    word_t value_mem [DEPTH];
    word_t rd_key_reg;
    word_t rd_value_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr]   <= wr_key;
            value_mem[wr_addr] <= wr_value;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_key_reg   <= key_mem[rd_addr];
        rd_value_reg <= value_mem[rd_addr];
    end

    assign rd_key   = rd_key_reg;
    assign rd_value = rd_value_reg;

endmodule

`default_nettype wire

### src/unique_key_fifo_unit.sv
// top level of the unique-key fifo: command sequencer, ring pointers and result register
// depends on ukf_pkg and ukf_store
`default_nettype none

// A fifo of key/value pairs in which no two held pairs share a key. An item is taken
// when start is high and busy is low; exactly one result follows, shown for one cycle
// with done high, and it cannot be held off, so capture it on that cycle. An enqueue
// walks the held keys one per cycle through the single read port of the store and
// compares each key as the registered read port returns it; on a match it stops with
// STATUS_DUPLICATE, else it appends the pair, or refuses it with STATUS_FULL when the
// queue already holds DEPTH pairs. A dequeue returns the pair at the head, or answers
// STATUS_EMPTY on an empty queue. busy is low again in the result cycle, and a new
// item may be started in that cycle.
module unique_key_fifo_unit #(
    parameter int DEPTH = 16
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 start,
    output logic                busy,
    input  wire                 command,
    input  wire signed [31:0]   key_in,
    input  wire signed [31:0]   value_in,
    output logic                done,
    output ukf_pkg::status_t    status,
    output logic signed [31:0]  key_out,
    output logic signed [31:0]  value_out,
    output logic [4:0]          occupancy,
    output logic                is_empty
);
    import ukf_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DEQ  = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [CW-1:0] issued_reg, issued_next;
    logic          pend_reg, pend_next;
    word_t         key_reg, key_next;
    word_t         value_reg, value_next;

    logic          done_reg, done_next;
    status_t       status_reg, status_next;
    word_t         kout_reg, kout_next;
    word_t         vout_reg, vout_next;
    logic [4:0]    occ_reg, occ_next;
    logic          empty_reg, empty_next;

    logic          wr_en;
    logic [AW-1:0] rd_addr;
    word_t         rd_key;
    word_t         rd_value;
    logic [31:0]   count_wide;

    function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] idx);
        ring_next = (idx == AW'(DEPTH - 1)) ? '0 : idx + AW'(1);
    endfunction

    ukf_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (tail_reg),
        .wr_key   (key_reg),
        .wr_value (value_reg),
        .rd_addr  (rd_addr),
        .rd_key   (rd_key),
        .rd_value (rd_value)
    );

    // scan walks from the head; otherwise keep the head addressed for a dequeue
    assign rd_addr = (state_reg == ST_SCAN) ? ptr_reg : head_reg;

    assign count_wide = 32'(count_next);

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        issued_next = issued_reg;
        pend_next   = 1'b0;
        key_next    = key_reg;
        value_next  = value_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        kout_next   = kout_reg;
        vout_next   = vout_reg;
        wr_en       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    key_next   = key_in;
                    value_next = value_in;
                    if (command == CMD_ENQUEUE)
                    begin
                        ptr_next    = head_reg;
                        issued_next = '0;
                        state_next  = ST_SCAN;
                    end
                    else if (count_reg == '0)
                    begin
                        done_next   = 1'b1;
                        status_next = STATUS_EMPTY;
                        kout_next   = '0;
                        vout_next   = '0;
                    end
                    else
                    begin
                        state_next = ST_DEQ;
                    end
                end
            end

            ST_SCAN:
            begin
                if (issued_reg < count_reg)
                begin
                    ptr_next    = ring_next(ptr_reg);
                    issued_next = issued_reg + CW'(1);
                    pend_next   = 1'b1;
                end
                kout_next = '0;
                vout_next = '0;
                if (pend_reg && rd_key == key_reg)
                begin
                    done_next   = 1'b1;
                    status_next = STATUS_DUPLICATE;
                    pend_next   = 1'b0;
                    state_next  = ST_IDLE;
                end
                else if (!pend_reg && issued_reg == count_reg)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                    if (count_reg == CW'(DEPTH))
                    begin
                        status_next = STATUS_FULL;
                    end
                    else
                    begin
                        wr_en       = 1'b1;
                        tail_next   = ring_next(tail_reg);
                        count_next  = count_reg + CW'(1);
                        status_next = STATUS_ENQUEUED;
                    end
                end
            end

            ST_DEQ:
            begin
                done_next   = 1'b1;
                status_next = STATUS_DEQUEUED;
                kout_next   = rd_key;
                vout_next   = rd_value;
                head_next   = ring_next(head_reg);
                count_next  = count_reg - CW'(1);
                state_next  = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        occ_next   = count_wide[4:0];
        empty_next = (count_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            head_reg   <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
            pend_reg   <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            pend_reg   <= pend_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg    <= ptr_next;
        issued_reg <= issued_next;
        key_reg    <= key_next;
        value_reg  <= value_next;
        status_reg <= status_next;
        kout_reg   <= kout_next;
        vout_reg   <= vout_next;
        occ_reg    <= occ_next;
        empty_reg  <= empty_next;
    end

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign status    = status_reg;
    assign key_out   = kout_reg;
    assign value_out = vout_reg;
    assign occupancy = occ_reg;
    assign is_empty  = empty_reg;

endmodule

`default_nettype wire
